### rtl/calendar_date_arithmetic_top_macros.svh
// Assertion macros for the calendar date arithmetic block.
// Used by calendar_date_arithmetic_top; expects clk and rst_n in scope.
`ifndef CALENDAR_DATE_ARITHMETIC_TOP_MACROS_SVH
`define CALENDAR_DATE_ARITHMETIC_TOP_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define CDT_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must be followed by a consequence in the next cycle.
`define CDT_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cdt_pkg.sv
// Package for the calendar date arithmetic block: types, calendar constants
// and month tables. No dependencies.
package cdt_pkg;

    // Field widths
    localparam int YEAR_BITS = 14;
    localparam int MON_BITS  = 4;
    localparam int DAY_BITS  = 5;
    localparam int ORD_BITS  = 22;
    localparam int STEP_BITS = 3;

    // Division of a year count by 100 through a reciprocal
    localparam int Q_BITS      = 8;
    localparam int R_BITS      = 7;
    localparam int RECIP_BITS  = 27;
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int YEARS_CENT  = 100;
    localparam int LAST_R      = 99;

    // Calendar constants
    localparam int unsigned DAYS_400 = 146097;
    localparam int unsigned DAYS_100 = 36524;
    localparam int unsigned DAYS_4   = 1461;
    localparam int unsigned DAYS_1   = 365;
    localparam int unsigned LAST_ORD = 3652059;
    localparam int MAX_YEAR   = 9999;
    localparam int MONTHS     = 12;
    localparam int W_400      = 400;
    localparam int W_100      = 100;
    localparam int W_4        = 4;
    localparam int CENT_CAP   = 3;
    localparam int YEAR_CAP   = 3;
    localparam int QUAD_LAST  = 24;
    localparam int STEP_TOP   = 4;
    localparam int SAT_DAY    = 31;
    localparam int EXTRA_BITS = 12;
    localparam int DBM_BITS   = 9;

    localparam logic [DAY_BITS-1:0] DIM_COMMON [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
    localparam logic [DAY_BITS-1:0] DIM_LEAP [0:12] = '{
        5'd0, 5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
    // Days in a common year before the first of each month
    localparam logic [DBM_BITS-1:0] DBM_COMMON [0:12] = '{
        9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

    typedef enum logic {
        CMD_DIFF = 1'b0,
        CMD_ADD  = 1'b1
    } cdt_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_DATE = 2'd1,
        STAT_ORDER    = 2'd2,
        STAT_OVERFLOW = 2'd3
    } cdt_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_Q,
        ST_DIV_R,
        ST_MUL,
        ST_ORD,
        ST_CMP,
        ST_SUM,
        ST_DEC,
        ST_OVF,
        ST_Q400,
        ST_Q100,
        ST_Q4,
        ST_Q1,
        ST_MON,
        ST_FIN
    } cdt_state_t;

    // Sequencer to datapath
    typedef struct packed {
        cdt_state_t             phase;
        logic [STEP_BITS-1:0]   step;
        logic                   second;
        logic                   busy;
    } cdt_ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        cdt_cmd_t cmd;
        logic     date_bad;
        logic     borrow;
        logic     cap_hit;
        logic     mon_last;
        logic     out_free;
    } cdt_stat_t;

    function automatic logic [DAY_BITS-1:0] month_len(input logic [MON_BITS-1:0] m,
                                                      input logic leap);
        logic [DAY_BITS-1:0] len;
        if (m == '0 || m > MON_BITS'(MONTHS))
            len = '0;
        else if (leap)
            len = DIM_LEAP[m];
        else
            len = DIM_COMMON[m];
        return len;
    endfunction

    function automatic logic [DBM_BITS-1:0] days_before_month(input logic [MON_BITS-1:0] m,
                                                              input logic leap);
        logic [DBM_BITS-1:0] n;
        if (m == '0 || m > MON_BITS'(MONTHS))
            n = '0;
        else
            n = DBM_COMMON[m] + DBM_BITS'(leap && (m > MON_BITS'(2)));
        return n;
    endfunction

endpackage

### rtl/cdt_alu.sv
// Shared add/subtract unit of the calendar date arithmetic block.
// Depends on nothing; width set by the instantiating module.
module cdt_alu #(
    parameter int WIDTH = 23
) (
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic             do_sub,
    output logic [WIDTH-1:0] result,
    output logic             borrow
);

    logic [WIDTH:0] ext;

    // Add or subtract with one extra bit for the borrow
    always_comb
    begin
        if (do_sub)
            ext = {1'b0, op_a} - {1'b0, op_b};
        else
            ext = {1'b0, op_a} + {1'b0, op_b};
    end

    assign result = ext[WIDTH-1:0];
    assign borrow = do_sub & ext[WIDTH];

endmodule

### rtl/cdt_seq.sv
// Sequencer of the calendar date arithmetic block.
// Depends on cdt_pkg for the state, control and status types.
module cdt_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  cdt_pkg::cdt_stat_t  stat,
    output cdt_pkg::cdt_ctrl_t  ctrl
);

    cdt_pkg::cdt_state_t                 state_reg, state_next;
    logic [cdt_pkg::STEP_BITS-1:0]       step_reg, step_next;
    logic                                second_reg, second_next;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cdt_pkg::ST_IDLE;
            step_reg   <= '0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            second_reg <= second_next;
        end
    end

    // Advance through the steps of one request
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        second_next = second_reg;
        unique case (state_reg)
            cdt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next  = cdt_pkg::ST_DIV_Q;
                    second_next = 1'b0;
                end
            end
            cdt_pkg::ST_DIV_Q: state_next = cdt_pkg::ST_DIV_R;
            cdt_pkg::ST_DIV_R:
            begin
                if (stat.date_bad)
                    state_next = cdt_pkg::ST_FIN;
                else
                    state_next = cdt_pkg::ST_MUL;
            end
            cdt_pkg::ST_MUL: state_next = cdt_pkg::ST_ORD;
            cdt_pkg::ST_ORD:
            begin
                if (stat.cmd == cdt_pkg::CMD_ADD)
                    state_next = cdt_pkg::ST_SUM;
                else if (second_reg)
                    state_next = cdt_pkg::ST_CMP;
                else
                begin
                    state_next  = cdt_pkg::ST_DIV_Q;
                    second_next = 1'b1;
                end
            end
            cdt_pkg::ST_CMP: state_next = cdt_pkg::ST_FIN;
            cdt_pkg::ST_SUM: state_next = cdt_pkg::ST_DEC;
            cdt_pkg::ST_DEC: state_next = cdt_pkg::ST_OVF;
            cdt_pkg::ST_OVF:
            begin
                if (!stat.borrow)
                    state_next = cdt_pkg::ST_FIN;
                else
                begin
                    state_next = cdt_pkg::ST_Q400;
                    step_next  = cdt_pkg::STEP_BITS'(cdt_pkg::STEP_TOP);
                end
            end
            cdt_pkg::ST_Q400:
            begin
                if (step_reg == '0)
                    state_next = cdt_pkg::ST_Q100;
                else
                    step_next = step_reg - 1'b1;
            end
            cdt_pkg::ST_Q100:
            begin
                if (stat.borrow || stat.cap_hit)
                begin
                    state_next = cdt_pkg::ST_Q4;
                    step_next  = cdt_pkg::STEP_BITS'(cdt_pkg::STEP_TOP);
                end
            end
            cdt_pkg::ST_Q4:
            begin
                if (step_reg == '0)
                    state_next = cdt_pkg::ST_Q1;
                else
                    step_next = step_reg - 1'b1;
            end
            cdt_pkg::ST_Q1:
            begin
                if (stat.borrow || stat.cap_hit)
                    state_next = cdt_pkg::ST_MON;
            end
            cdt_pkg::ST_MON:
            begin
                if (stat.borrow || stat.mon_last)
                    state_next = cdt_pkg::ST_FIN;
            end
            cdt_pkg::ST_FIN:
            begin
                if (stat.out_free)
                    state_next = cdt_pkg::ST_IDLE;
            end
            default: state_next = cdt_pkg::ST_IDLE;
        endcase
    end

    // Drive the control group
    always_comb
    begin
        ctrl.phase  = state_reg;
        ctrl.step   = step_reg;
        ctrl.second = second_reg;
        ctrl.busy   = (state_reg != cdt_pkg::ST_IDLE);
    end

endmodule

### rtl/calendar_date_arithmetic_top.sv
// Top level of the calendar date arithmetic block: request capture, datapath
// registers, result register. Depends on cdt_pkg, cdt_alu, cdt_seq, macro header.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  request | req_valid, req_stall | cmd, first_*, second_*, add_count
//  result  | res_valid, res_stall | status, diff_days, new_day, new_month, new_year
//
// One request at a time; req_stall is high from acceptance until the result
// is written into the result register. An invalid date ends a request early. Days
// between dates turns both dates into ordinals and compares them; adding days adds
// add_count to the first ordinal, checks overflow, then runs the year search and
// the month walk, the month walk being the longest loop. A waiting result does not
// block acceptance of the next request; that request holds in its final step until
// the result register frees. Reset clears the sequencer and the result valid flag.
`include "calendar_date_arithmetic_top_macros.svh"

module calendar_date_arithmetic_top #(
    parameter int ADD_COUNT_BITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          cmd,
    input  logic [cdt_pkg::DAY_BITS-1:0]  first_day,
    input  logic [cdt_pkg::MON_BITS-1:0]  first_month,
    input  logic [cdt_pkg::YEAR_BITS-1:0] first_year,
    input  logic [cdt_pkg::DAY_BITS-1:0]  second_day,
    input  logic [cdt_pkg::MON_BITS-1:0]  second_month,
    input  logic [cdt_pkg::YEAR_BITS-1:0] second_year,
    input  logic [ADD_COUNT_BITS-1:0]     add_count,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [1:0]                    status,
    output logic [cdt_pkg::ORD_BITS-1:0]  diff_days,
    output logic [cdt_pkg::DAY_BITS-1:0]  new_day,
    output logic [cdt_pkg::MON_BITS-1:0]  new_month,
    output logic [cdt_pkg::YEAR_BITS-1:0] new_year
);

    localparam int ACC_BITS =
        ((ADD_COUNT_BITS > cdt_pkg::ORD_BITS) ? ADD_COUNT_BITS : cdt_pkg::ORD_BITS) + 1;
    localparam int YB = cdt_pkg::YEAR_BITS;
    localparam int MB = cdt_pkg::MON_BITS;
    localparam int DB = cdt_pkg::DAY_BITS;

    cdt_pkg::cdt_ctrl_t ctrl;
    cdt_pkg::cdt_stat_t stat;

    // Captured request
    cdt_pkg::cdt_cmd_t        cmd_reg;
    logic [DB-1:0]            d1_reg, d2_reg;
    logic [MB-1:0]            m1_reg, m2_reg;
    logic [YB-1:0]            y1_reg, y2_reg;
    logic [ADD_COUNT_BITS-1:0] cnt_reg;

    // Working registers
    cdt_pkg::cdt_status_t             st_reg;
    logic [cdt_pkg::Q_BITS-1:0]       q_reg;
    logic [cdt_pkg::R_BITS-1:0]       r_reg;
    logic                             leap_reg;
    logic [ACC_BITS-1:0]              acc_reg;
    logic [cdt_pkg::ORD_BITS-1:0]     o1_reg, o2_reg;
    logic [YB-1:0]                    year_reg;
    logic [1:0]                       n100_reg, n1_reg;
    logic [4:0]                       n4_reg;
    logic [MB-1:0]                    mon_reg;

    // Result register
    logic                             res_valid_reg, res_valid_next;
    cdt_pkg::cdt_status_t             status_reg;
    logic [cdt_pkg::ORD_BITS-1:0]     diff_reg;
    logic [DB-1:0]                    nd_reg;
    logic [MB-1:0]                    nm_reg;
    logic [YB-1:0]                    ny_reg;

    // Combinational datapath
    logic [DB-1:0]                    cur_d;
    logic [MB-1:0]                    cur_m;
    logic [YB-1:0]                    cur_y;
    logic [YB-1:0]                    p;
    logic [cdt_pkg::RECIP_BITS-1:0]   q_prod;
    logic [YB-1:0]                    r_full;
    logic [cdt_pkg::R_BITS-1:0]       r_cur;
    logic [cdt_pkg::R_BITS-1:0]       r_plus1;
    logic [cdt_pkg::Q_BITS-1:0]       q_plus1;
    logic                             leap_cur;
    logic                             date_ok;
    logic [cdt_pkg::EXTRA_BITS-1:0]   extra;
    logic                             leap_res;
    logic [ACC_BITS-1:0]              alu_a, alu_b, alu_res;
    logic                             alu_sub, alu_borrow;
    logic                             accept, out_free;

    assign accept    = req_valid && !ctrl.busy;
    assign req_stall = ctrl.busy;
    assign out_free  = !res_valid_reg || !res_stall;

    cdt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    cdt_alu #(.WIDTH(ACC_BITS)) u_alu (
        .op_a   (alu_a),
        .op_b   (alu_b),
        .do_sub (alu_sub),
        .result (alu_res),
        .borrow (alu_borrow)
    );

    // Select the date being worked on
    always_comb
    begin
        if (ctrl.second)
        begin
            cur_d = d2_reg;
            cur_m = m2_reg;
            cur_y = y2_reg;
        end
        else
        begin
            cur_d = d1_reg;
            cur_m = m1_reg;
            cur_y = y1_reg;
        end
    end

    // Split the elapsed years into centuries and remainder
    assign p       = cur_y - YB'(1);
    assign q_prod  = cdt_pkg::RECIP_BITS'(p) * cdt_pkg::RECIP_BITS'(cdt_pkg::RECIP_100);
    assign r_full  = p - YB'(YB'(q_reg) * YB'(cdt_pkg::YEARS_CENT));
    assign r_cur   = r_full[cdt_pkg::R_BITS-1:0];
    assign r_plus1 = r_cur + 1'b1;
    assign q_plus1 = q_reg + 1'b1;

    // Leap test of the year itself, from the split of the year before it
    always_comb
    begin
        if (r_cur == cdt_pkg::R_BITS'(cdt_pkg::LAST_R))
            leap_cur = (q_plus1[1:0] == 2'b00);
        else
            leap_cur = (r_plus1[1:0] == 2'b00);
    end

    assign date_ok = (cur_y != '0) && (cur_y <= YB'(cdt_pkg::MAX_YEAR))
                  && (cur_m != '0) && (cur_m <= MB'(cdt_pkg::MONTHS))
                  && (cur_d != '0) && (cur_d <= cdt_pkg::month_len(cur_m, leap_cur));

    // Leap days, day of month and month offset added to 365 days a year
    assign extra = cdt_pkg::EXTRA_BITS'(q_reg) * cdt_pkg::EXTRA_BITS'(24)
                 + cdt_pkg::EXTRA_BITS'(r_reg[cdt_pkg::R_BITS-1:2])
                 + cdt_pkg::EXTRA_BITS'(q_reg[cdt_pkg::Q_BITS-1:2])
                 + cdt_pkg::EXTRA_BITS'(cur_d)
                 + cdt_pkg::EXTRA_BITS'(cdt_pkg::days_before_month(cur_m, leap_reg));

    assign leap_res = (n1_reg == 2'(cdt_pkg::YEAR_CAP))
                   && ((n4_reg != 5'(cdt_pkg::QUAD_LAST)) || (n100_reg == 2'(cdt_pkg::CENT_CAP)));

    // Feed the shared unit
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = '0;
        alu_sub = 1'b1;
        unique case (ctrl.phase)
            cdt_pkg::ST_ORD:
            begin
                alu_b   = ACC_BITS'(extra);
                alu_sub = 1'b0;
            end
            cdt_pkg::ST_CMP:
            begin
                alu_a = ACC_BITS'(o1_reg);
                alu_b = ACC_BITS'(o2_reg);
            end
            cdt_pkg::ST_SUM:
            begin
                alu_a   = ACC_BITS'(o1_reg);
                alu_b   = ACC_BITS'(cnt_reg);
                alu_sub = 1'b0;
            end
            cdt_pkg::ST_DEC:  alu_b = ACC_BITS'(1);
            cdt_pkg::ST_OVF:  alu_b = ACC_BITS'(cdt_pkg::LAST_ORD);
            cdt_pkg::ST_Q400: alu_b = ACC_BITS'(cdt_pkg::DAYS_400) << ctrl.step;
            cdt_pkg::ST_Q100: alu_b = ACC_BITS'(cdt_pkg::DAYS_100);
            cdt_pkg::ST_Q4:   alu_b = ACC_BITS'(cdt_pkg::DAYS_4) << ctrl.step;
            cdt_pkg::ST_Q1:   alu_b = ACC_BITS'(cdt_pkg::DAYS_1);
            cdt_pkg::ST_MON:  alu_b = ACC_BITS'(cdt_pkg::month_len(mon_reg, leap_res));
            cdt_pkg::ST_IDLE, cdt_pkg::ST_DIV_Q, cdt_pkg::ST_DIV_R, cdt_pkg::ST_MUL,
            cdt_pkg::ST_FIN:
            begin
                alu_sub = 1'b0;
            end
            default: alu_sub = 1'b0;
        endcase
    end

    // Status back to the sequencer
    always_comb
    begin
        stat.cmd      = cmd_reg;
        stat.date_bad = !date_ok;
        stat.borrow   = alu_borrow;
        if (ctrl.phase == cdt_pkg::ST_Q100)
            stat.cap_hit = (n100_reg == 2'(cdt_pkg::CENT_CAP));
        else
            stat.cap_hit = (n1_reg == 2'(cdt_pkg::YEAR_CAP));
        stat.mon_last = (mon_reg == MB'(cdt_pkg::MONTHS));
        stat.out_free = out_free;
    end

    // Update the working registers one step at a time
    always_ff @(posedge clk)
    begin
        unique case (ctrl.phase)
            cdt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg <= cdt_pkg::cdt_cmd_t'(cmd);
                    d1_reg  <= first_day;
                    m1_reg  <= first_month;
                    y1_reg  <= first_year;
                    d2_reg  <= second_day;
                    m2_reg  <= second_month;
                    y2_reg  <= second_year;
                    cnt_reg <= add_count;
                    st_reg  <= cdt_pkg::STAT_OK;
                end
            end
            cdt_pkg::ST_DIV_Q:
            begin
                q_reg <= q_prod[cdt_pkg::RECIP_SHIFT +: cdt_pkg::Q_BITS];
            end
            cdt_pkg::ST_DIV_R:
            begin
                r_reg    <= r_cur;
                leap_reg <= leap_cur;
                if (!date_ok)
                    st_reg <= cdt_pkg::STAT_BAD_DATE;
            end
            cdt_pkg::ST_MUL:
            begin
                acc_reg <= ACC_BITS'(p) * ACC_BITS'(cdt_pkg::DAYS_1);
            end
            cdt_pkg::ST_ORD:
            begin
                acc_reg <= alu_res;
                if (ctrl.second)
                    o2_reg <= alu_res[cdt_pkg::ORD_BITS-1:0];
                else
                    o1_reg <= alu_res[cdt_pkg::ORD_BITS-1:0];
            end
            cdt_pkg::ST_CMP:
            begin
                if (alu_borrow)
                    st_reg <= cdt_pkg::STAT_ORDER;
                else
                    acc_reg <= alu_res;
            end
            cdt_pkg::ST_SUM, cdt_pkg::ST_DEC:
            begin
                acc_reg <= alu_res;
            end
            cdt_pkg::ST_OVF:
            begin
                if (!alu_borrow)
                    st_reg <= cdt_pkg::STAT_OVERFLOW;
                year_reg <= YB'(1);
                n100_reg <= '0;
                n4_reg   <= '0;
                n1_reg   <= '0;
                mon_reg  <= MB'(1);
            end
            cdt_pkg::ST_Q400:
            begin
                if (!alu_borrow)
                begin
                    acc_reg  <= alu_res;
                    year_reg <= year_reg + (YB'(cdt_pkg::W_400) << ctrl.step);
                end
            end
            cdt_pkg::ST_Q100:
            begin
                if (!alu_borrow && !stat.cap_hit)
                begin
                    acc_reg  <= alu_res;
                    n100_reg <= n100_reg + 1'b1;
                    year_reg <= year_reg + YB'(cdt_pkg::W_100);
                end
            end
            cdt_pkg::ST_Q4:
            begin
                if (!alu_borrow)
                begin
                    acc_reg  <= alu_res;
                    n4_reg   <= n4_reg | (5'(1) << ctrl.step);
                    year_reg <= year_reg + (YB'(cdt_pkg::W_4) << ctrl.step);
                end
            end
            cdt_pkg::ST_Q1:
            begin
                if (!alu_borrow && !stat.cap_hit)
                begin
                    acc_reg  <= alu_res;
                    n1_reg   <= n1_reg + 1'b1;
                    year_reg <= year_reg + YB'(1);
                end
            end
            cdt_pkg::ST_MON:
            begin
                if (!alu_borrow && !stat.mon_last)
                begin
                    acc_reg <= alu_res;
                    mon_reg <= mon_reg + 1'b1;
                end
            end
            cdt_pkg::ST_FIN:
            begin
                acc_reg <= acc_reg;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // Result valid: set when a finished request lands, drop when taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (ctrl.phase == cdt_pkg::ST_FIN && out_free)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    // Load the result payload, each field once per status
    always_ff @(posedge clk)
    begin
        if (ctrl.phase == cdt_pkg::ST_FIN && out_free)
        begin
            status_reg <= st_reg;
            unique case (st_reg)
                cdt_pkg::STAT_OK:
                begin
                    if (cmd_reg == cdt_pkg::CMD_ADD)
                    begin
                        diff_reg <= '0;
                        nd_reg   <= acc_reg[DB-1:0] + DB'(1);
                        nm_reg   <= mon_reg;
                        ny_reg   <= year_reg;
                    end
                    else
                    begin
                        diff_reg <= acc_reg[cdt_pkg::ORD_BITS-1:0];
                        nd_reg   <= '0;
                        nm_reg   <= '0;
                        ny_reg   <= '0;
                    end
                end
                cdt_pkg::STAT_OVERFLOW:
                begin
                    diff_reg <= '0;
                    nd_reg   <= DB'(cdt_pkg::SAT_DAY);
                    nm_reg   <= MB'(cdt_pkg::MONTHS);
                    ny_reg   <= YB'(cdt_pkg::MAX_YEAR);
                end
                cdt_pkg::STAT_BAD_DATE, cdt_pkg::STAT_ORDER:
                begin
                    diff_reg <= '0;
                    nd_reg   <= '0;
                    nm_reg   <= '0;
                    ny_reg   <= '0;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign diff_days = diff_reg;
    assign new_day   = nd_reg;
    assign new_month = nm_reg;
    assign new_year  = ny_reg;

    // Checks
    `CDT_CHECK_NEXT(a_accept_starts, req_valid && !req_stall,
                    ctrl.phase == cdt_pkg::ST_DIV_Q && !ctrl.second,
                    "accepted request did not start the first date")
    `CDT_CHECK(a_month_range, (ctrl.phase == cdt_pkg::ST_MON)
               |-> (mon_reg != '0 && mon_reg <= MB'(cdt_pkg::MONTHS)),
               "month walk left 1..12")
    `CDT_CHECK(a_year_range, (ctrl.phase == cdt_pkg::ST_MON)
               |-> (year_reg != '0 && year_reg <= YB'(cdt_pkg::MAX_YEAR)),
               "year search left 1..9999")
    `CDT_CHECK(a_error_zero, (res_valid && (status == cdt_pkg::STAT_BAD_DATE
               || status == cdt_pkg::STAT_ORDER)) |-> (diff_days == '0 && new_day == '0
               && new_month == '0 && new_year == '0),
               "error result carries nonzero fields")
    `CDT_CHECK_NEXT(a_fin_loads, ctrl.phase == cdt_pkg::ST_FIN && out_free,
                    res_valid && ctrl.phase == cdt_pkg::ST_IDLE,
                    "finished request not handed to result register")

endmodule

### test/calendar_date_arithmetic_top_tb.sv
// Testbench for calendar_date_arithmetic_top: day counts between dates and day addition.
// Depends on cdt_pkg and the calendar_date_arithmetic_top RTL; uses no files or arguments.
module calendar_date_arithmetic_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cdt_pkg::*;

    localparam int CNT_BITS     = 20;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        cdt_cmd_t              cmd;
        logic [DAY_BITS-1:0]   d1;
        logic [MON_BITS-1:0]   m1;
        logic [YEAR_BITS-1:0]  y1;
        logic [DAY_BITS-1:0]   d2;
        logic [MON_BITS-1:0]   m2;
        logic [YEAR_BITS-1:0]  y2;
        logic [CNT_BITS-1:0]   cnt;
    } date_req_t;

    typedef struct packed {
        cdt_status_t           status;
        logic [ORD_BITS-1:0]   diff;
        logic [DAY_BITS-1:0]   day;
        logic [MON_BITS-1:0]   month;
        logic [YEAR_BITS-1:0]  year;
    } date_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic                  cmd = 1'b0;
    logic [DAY_BITS-1:0]   first_day = '0;
    logic [MON_BITS-1:0]   first_month = '0;
    logic [YEAR_BITS-1:0]  first_year = '0;
    logic [DAY_BITS-1:0]   second_day = '0;
    logic [MON_BITS-1:0]   second_month = '0;
    logic [YEAR_BITS-1:0]  second_year = '0;
    logic [CNT_BITS-1:0]   add_count = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [1:0]            status;
    logic [ORD_BITS-1:0]   diff_days;
    logic [DAY_BITS-1:0]   new_day;
    logic [MON_BITS-1:0]   new_month;
    logic [YEAR_BITS-1:0]  new_year;

    date_res_t   awaited_results[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          steady = 1'b0;

    calendar_date_arithmetic_top #(
        .ADD_COUNT_BITS(CNT_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .cmd          (cmd),
        .first_day    (first_day),
        .first_month  (first_month),
        .first_year   (first_year),
        .second_day   (second_day),
        .second_month (second_month),
        .second_year  (second_year),
        .add_count    (add_count),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .status       (status),
        .diff_days    (diff_days),
        .new_day      (new_day),
        .new_month    (new_month),
        .new_year     (new_year)
    );

    // Free-running clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** calendar_date_arithmetic_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Calendar arithmetic
    // ------------------------------------------------------------------

    function automatic bit is_leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        if (m < 1 || m > 12)
            return 0;
        if (m == 2)
            return is_leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic bit date_valid(int unsigned d, int unsigned m, int unsigned y);
        return (y >= 1) && (y <= MAX_YEAR) && (m >= 1) && (m <= 12)
            && (d >= 1) && (d <= month_days(m, y));
    endfunction

    // Days in all years ahead of year y
    function automatic int unsigned years_days(int unsigned y);
        int unsigned p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    // Day number counted from 1 January of year 1 as day 1
    function automatic int unsigned day_number(int unsigned d, int unsigned m, int unsigned y);
        int unsigned n;
        n = years_days(y) + d;
        for (int unsigned i = 1; i < m; i++)
            n += month_days(i, y);
        return n;
    endfunction

    function automatic date_res_t compute_date_result(date_req_t r);
        date_res_t   res;
        int unsigned a, b, t, yr, mo, doy;
        longint unsigned total;
        res = '0;
        res.status = STAT_OK;
        if (r.cmd == CMD_DIFF) begin
            if (!date_valid(r.d1, r.m1, r.y1) || !date_valid(r.d2, r.m2, r.y2)) begin
                res.status = STAT_BAD_DATE;
            end else begin
                a = day_number(r.d1, r.m1, r.y1);
                b = day_number(r.d2, r.m2, r.y2);
                if (b > a)
                    res.status = STAT_ORDER;
                else
                    res.diff = ORD_BITS'(a - b);
            end
        end else if (!date_valid(r.d1, r.m1, r.y1)) begin
            res.status = STAT_BAD_DATE;
        end else begin
            total = longint'(day_number(r.d1, r.m1, r.y1)) + longint'(r.cnt);
            if (total > longint'(years_days(MAX_YEAR + 1))) begin
                res.status = STAT_OVERFLOW;
                res.day    = DAY_BITS'(31);
                res.month  = MON_BITS'(12);
                res.year   = YEAR_BITS'(MAX_YEAR);
            end else begin
                t = int'(total);
                // start at or below the true year, then walk up
                yr = (t - 1) / 366 + 1;
                while (yr < MAX_YEAR && years_days(yr + 1) < t)
                    yr++;
                doy = t - years_days(yr);
                mo = 1;
                while (doy > month_days(mo, yr)) begin
                    doy -= month_days(mo, yr);
                    mo++;
                end
                res.day   = DAY_BITS'(doy);
                res.month = MON_BITS'(mo);
                res.year  = YEAR_BITS'(yr);
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    function automatic date_req_t make_req(cdt_cmd_t c,
                                           int unsigned d1, int unsigned m1, int unsigned y1,
                                           int unsigned d2, int unsigned m2, int unsigned y2,
                                           int unsigned cnt);
        date_req_t r;
        r.cmd = c;
        r.d1  = DAY_BITS'(d1);
        r.m1  = MON_BITS'(m1);
        r.y1  = YEAR_BITS'(y1);
        r.d2  = DAY_BITS'(d2);
        r.m2  = MON_BITS'(m2);
        r.y2  = YEAR_BITS'(y2);
        r.cnt = CNT_BITS'(cnt);
        return r;
    endfunction

    // Present one request, hold it until accepted, then queue its result
    task automatic send_request(input date_req_t r);
        if (!steady && $urandom_range(0, 99) < 11) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_valid    <= 1'b1;
        cmd          <= r.cmd;
        first_day    <= r.d1;
        first_month  <= r.m1;
        first_year   <= r.y1;
        second_day   <= r.d2;
        second_month <= r.m2;
        second_year  <= r.y2;
        add_count    <= r.cnt;
        do
            @(posedge clk);
        while (req_stall);
        awaited_results.push_back(compute_date_result(r));
    endtask

    // Random valid date, biased toward the ends of the range and century years
    function automatic void pick_date(output logic [DAY_BITS-1:0] d,
                                      output logic [MON_BITS-1:0] m,
                                      output logic [YEAR_BITS-1:0] y);
        int unsigned yr, mo, len, sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            yr = ($urandom_range(0, 1) != 0) ? MAX_YEAR : 1;
        else if (sel == 1)
            yr = 1900 + 100 * $urandom_range(0, 5);
        else
            yr = $urandom_range(1, MAX_YEAR);
        mo  = $urandom_range(1, 12);
        len = month_days(mo, yr);
        d = DAY_BITS'(($urandom_range(0, 4) == 0) ? len : $urandom_range(1, len));
        m = MON_BITS'(mo);
        y = YEAR_BITS'(yr);
    endfunction

    function automatic int unsigned pick_count();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 31);
            1:       return $urandom_range(0, 400);
            2:       return $urandom_range(0, 40000);
            default: return $urandom_range(0, (1 << CNT_BITS) - 1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall the result channel at random unless in a steady stretch
    always @(posedge clk)
    begin
        res_stall <= !steady && ($urandom_range(0, 99) < 11);
    end

    task automatic report_mismatch(input string what, input date_res_t want,
                                   input date_res_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t %s: expected status %0d diff %0d date %0d-%0d-%0d, got status %0d diff %0d date %0d-%0d-%0d",
                     $realtime, what, want.status, want.diff, want.year, want.month, want.day,
                     got.status, got.diff, got.year, got.month, got.day);
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        date_res_t got;
        date_res_t want;
        if (rst_n && res_valid && !res_stall) begin
            got.status = cdt_status_t'(status);
            got.diff   = diff_days;
            got.day    = new_day;
            got.month  = new_month;
            got.year   = new_year;
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = awaited_results.pop_front();
                if (got !== want)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_days_between_directed();
        send_request(make_req(CMD_DIFF, 1, 1, 2000, 1, 1, 2000, 0));
        send_request(make_req(CMD_DIFF, 31, 12, MAX_YEAR, 1, 1, 1, 0));
        send_request(make_req(CMD_DIFF, 29, 2, 2000, 29, 2, 1996, 0));
        send_request(make_req(CMD_DIFF, 1, 3, 2100, 28, 2, 2100, 0));
        // second date later than first
        send_request(make_req(CMD_DIFF, 1, 1, 2000, 2, 1, 2000, 0));
        // invalid dates on either side
        send_request(make_req(CMD_DIFF, 29, 2, 1900, 1, 1, 1, 0));
        send_request(make_req(CMD_DIFF, 1, 1, 2000, 0, 1, 1999, 0));
        send_request(make_req(CMD_DIFF, 31, 4, 2001, 1, 1, 2000, 0));
        send_request(make_req(CMD_DIFF, 1, 13, 2001, 1, 1, 2000, 0));
        send_request(make_req(CMD_DIFF, 1, 1, 0, 1, 1, 1, 0));
        send_request(make_req(CMD_DIFF, 1, 1, 10000, 1, 1, 1, 0));
        send_request(make_req(CMD_DIFF, 31, 15, 16383, 31, 15, 16383, 0));
    endtask

    task automatic test_add_days_directed();
        send_request(make_req(CMD_ADD, 15, 6, 2024, 0, 0, 0, 0));
        send_request(make_req(CMD_ADD, 28, 2, 2000, 31, 15, 16383, 1));
        send_request(make_req(CMD_ADD, 28, 2, 1900, 0, 0, 0, 1));
        send_request(make_req(CMD_ADD, 31, 12, 1999, 0, 0, 0, 1));
        send_request(make_req(CMD_ADD, 1, 1, 1, 0, 0, 0, (1 << CNT_BITS) - 1));
        send_request(make_req(CMD_ADD, 31, 12, MAX_YEAR, 0, 0, 0, 0));
        send_request(make_req(CMD_ADD, 30, 12, MAX_YEAR, 0, 0, 0, 1));
        // run past the last representable date
        send_request(make_req(CMD_ADD, 31, 12, MAX_YEAR, 0, 0, 0, 1));
        send_request(make_req(CMD_ADD, 1, 1, 9000, 0, 0, 0, (1 << CNT_BITS) - 1));
        // invalid first date
        send_request(make_req(CMD_ADD, 29, 2, 2100, 1, 1, 1, 5));
        send_request(make_req(CMD_ADD, 0, 0, 0, 1, 1, 1, 5));
    endtask

    // Well-formed requests with random content
    task automatic test_random_calendar(input int unsigned n);
        date_req_t r;
        date_req_t tmp;
        for (int unsigned i = 0; i < n; i++) begin
            r.cmd = ($urandom_range(0, 1) != 0) ? CMD_ADD : CMD_DIFF;
            pick_date(r.d1, r.m1, r.y1);
            pick_date(r.d2, r.m2, r.y2);
            r.cnt = '0;
            if (r.cmd == CMD_ADD) begin
                r.cnt = CNT_BITS'(pick_count());
                r.d2  = DAY_BITS'($urandom);
                r.m2  = MON_BITS'($urandom);
                r.y2  = YEAR_BITS'($urandom);
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    // same year, often close together
                    r.y2 = r.y1;
                    if (r.d2 > month_days(r.m2, r.y2))
                        r.d2 = DAY_BITS'(month_days(r.m2, r.y2));
                end
                // order most pairs so that the second date is earlier
                if ($urandom_range(0, 99) < 85 &&
                    day_number(r.d2, r.m2, r.y2) > day_number(r.d1, r.m1, r.y1)) begin
                    tmp  = r;
                    r.d1 = tmp.d2;
                    r.m1 = tmp.m2;
                    r.y1 = tmp.y2;
                    r.d2 = tmp.d1;
                    r.m2 = tmp.m1;
                    r.y2 = tmp.y1;
                end
            end
            send_request(r);
        end
    endtask

    // Raw field values and dates broken in one field
    task automatic test_malformed_dates(input int unsigned n);
        date_req_t r;
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) != 0) begin
                r.cmd = ($urandom_range(0, 1) != 0) ? CMD_ADD : CMD_DIFF;
                r.d1  = DAY_BITS'($urandom);
                r.m1  = MON_BITS'($urandom);
                r.y1  = YEAR_BITS'($urandom);
                r.d2  = DAY_BITS'($urandom);
                r.m2  = MON_BITS'($urandom);
                r.y2  = YEAR_BITS'($urandom);
                r.cnt = CNT_BITS'($urandom);
            end else begin
                r.cmd = ($urandom_range(0, 1) != 0) ? CMD_ADD : CMD_DIFF;
                pick_date(r.d1, r.m1, r.y1);
                pick_date(r.d2, r.m2, r.y2);
                r.cnt = CNT_BITS'(pick_count());
                case ($urandom_range(0, 3))
                    0: r.d1 = DAY_BITS'($urandom_range(month_days(r.m1, r.y1) + 1, 31));
                    1: r.d1 = '0;
                    2: r.m1 = ($urandom_range(0, 1) != 0) ? MON_BITS'(0)
                                                          : MON_BITS'($urandom_range(13, 15));
                    default: r.y1 = ($urandom_range(0, 1) != 0) ? YEAR_BITS'(0)
                                    : YEAR_BITS'($urandom_range(MAX_YEAR + 1, 16383));
                endcase
            end
            send_request(r);
        end
    endtask

    // No idling on either side
    task automatic test_back_to_back(input int unsigned n);
        steady = 1'b1;
        test_random_calendar(n);
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_days_between_directed();
        test_add_days_directed();
        test_random_calendar(600);
        test_back_to_back(200);
        test_malformed_dates(250);
        test_random_calendar(450);

        // drop valid after the last request and drain
        req_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("** calendar_date_arithmetic_top: PASSED **");
        else
            $display("** calendar_date_arithmetic_top: FAILED **");
        $finish;
    end

endmodule
